// ===== rtl/core/rdrp_pkg.sv =====
// ----------------------------------------------------------------------------
// rdrp_pkg
// Shared codes, constants and a helper function for the reuse distance replacement policy.
// ----------------------------------------------------------------------------
package rdrp_pkg;

    // Command codes
    localparam logic CMD_VICTIM = 1'b0;
    localparam logic CMD_RECORD = 1'b1;

    // Fixed port field widths
    localparam int SET_IN_W = 6;
    localparam int WAY_IN_W = 4;
    localparam int VICTIM_W = 4;

    // Hit epoch of 32 hits, aging every 8 misses, estimate is sum >> 4
    localparam int HIT_CNT_W  = 5;
    localparam int MISS_CNT_W = 3;
    localparam int EST_SHIFT  = 4;

    // Priority field: at most 8 + 1 + 1
    localparam int PRIO_W = 4;
    localparam logic [PRIO_W-1:0] PRIO_NEAR = 4'd8;
    localparam logic [PRIO_W-1:0] PRIO_PAD  = 4'hF;

    // Address width of a memory of the given depth (at least one bit)
    function automatic int f_addr_w(input int depth);
        int w;
        w = 1;
        while ((1 << w) < depth) begin
            w = w + 1;
        end
        return w;
    endfunction

endpackage

// ===== rtl/core/rdrp_ram.sv =====
// ----------------------------------------------------------------------------
// rdrp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rdrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [rdrp_pkg::f_addr_w(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [rdrp_pkg::f_addr_w(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/reuse_distance_replacement_policy.sv =====
// ----------------------------------------------------------------------------
// reuse_distance_replacement_policy
// Per-set line ages and flags plus reuse-distance statistics held in one
// set-indexed RAM; victim selection and access records by read-modify-write.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                                   Transfer
//  request   in         start, i_command, i_set_index,            start & !busy
//                       i_way_index, i_is_prefetch, i_was_hit
//  victim    out        o_valid, o_victim_way                     o_valid
//
//  The set row is read at the transfer and the updated row is written back in
//  the next cycle, the execute state, in which busy is high. The victim on
//  o_victim_way and a one-cycle o_valid strobe are registered from that state.
//  After reset a clearing pass writes SETS rows, one per cycle, with busy high
//  throughout. The receiver cannot stall; access records give no result.
// ----------------------------------------------------------------------------
module reuse_distance_replacement_policy #(
    parameter int SETS     = 64,
    parameter int WAYS     = 16,
    parameter int AGE_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_command,
    input  logic [rdrp_pkg::SET_IN_W-1:0]   i_set_index,
    input  logic [rdrp_pkg::WAY_IN_W-1:0]   i_way_index,
    input  logic                            i_is_prefetch,
    input  logic                            i_was_hit,
    output logic                            o_valid,
    output logic [rdrp_pkg::VICTIM_W-1:0]   o_victim_way
);

    localparam int SET_W = rdrp_pkg::f_addr_w(SETS);
    localparam int WAY_W = rdrp_pkg::f_addr_w(WAYS);
    localparam int NPAD  = 1 << WAY_W;
    localparam int SUM_W = AGE_BITS + rdrp_pkg::HIT_CNT_W;
    localparam int EST_W = SUM_W - rdrp_pkg::EST_SHIFT;

    typedef struct packed {
        logic [EST_W-1:0]                  est;
        logic [SUM_W-1:0]                  sum;
        logic [rdrp_pkg::MISS_CNT_W-1:0]   misses;
        logic [rdrp_pkg::HIT_CNT_W-1:0]    hits;
        logic [WAYS-1:0]                   reused;
        logic [WAYS-1:0]                   demand;
        logic [WAYS-1:0][AGE_BITS-1:0]     age;
    } t_row;

    typedef struct packed {
        logic [rdrp_pkg::PRIO_W-1:0] prio;
        logic [AGE_BITS-1:0]         age;
        logic [WAY_W-1:0]            way;
    } t_key;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    localparam int ROW_W = $bits(t_row);

    t_state               r_state;
    logic [SET_W-1:0]     r_clr_addr;
    logic                 r_valid;
    logic [rdrp_pkg::VICTIM_W-1:0] r_victim;

    // Request captured at transfer
    logic                 r_cmd;
    logic [SET_W-1:0]     r_set;
    logic [WAY_W-1:0]     r_way;
    logic                 r_set_ok;
    logic                 r_way_ok;
    logic                 r_pf;
    logic                 r_hit;

    logic                 accept;
    logic                 ram_we;
    logic [SET_W-1:0]     ram_waddr;
    logic [ROW_W-1:0]     ram_wdata;
    logic [ROW_W-1:0]     ram_rdata;
    t_row                 cur_row;
    t_row                 n_row;
    t_key                 best;

    assign accept  = start && !busy;
    assign busy    = (r_state != ST_IDLE);
    assign cur_row = t_row'(ram_rdata);

    // Set metadata memory
    rdrp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (SET_W'(i_set_index)),
        .o_rdata (ram_rdata)
    );

    // Write port: clearing pass, else write back of an access record
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_set;
        ram_wdata = ROW_W'(n_row);
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (r_state == ST_EXEC) begin
            ram_we = (r_cmd == rdrp_pkg::CMD_RECORD) && r_set_ok && r_way_ok;
        end
    end

    // Row update for an access record
    always_comb begin
        logic [SUM_W-1:0] sum_tmp;
        n_row   = cur_row;
        sum_tmp = cur_row.sum + SUM_W'(cur_row.age[r_way]);
        if (r_hit) begin
            if (cur_row.hits == '1) begin
                n_row.est  = EST_W'(sum_tmp >> rdrp_pkg::EST_SHIFT);
                n_row.sum  = '0;
                n_row.hits = '0;
            end else begin
                n_row.sum  = sum_tmp;
                n_row.hits = cur_row.hits + 1'b1;
            end
        end else begin
            if (cur_row.misses == '1) begin
                n_row.misses = '0;
                for (int w = 0; w < WAYS; w++) begin
                    if (cur_row.age[w] != '1) begin
                        n_row.age[w] = cur_row.age[w] + 1'b1;
                    end
                end
            end else begin
                n_row.misses = cur_row.misses + 1'b1;
            end
        end
        n_row.age[r_way]    = '0;
        n_row.demand[r_way] = !r_pf;
        n_row.reused[r_way] = r_hit;
    end

    // Victim search: min tree over {priority, age}, ties to the left (lower way)
    always_comb begin
        t_key tree [2*NPAD-1];
        for (int i = 0; i < NPAD; i++) begin
            if (i < WAYS) begin
                tree[NPAD-1+i].prio =
                    ((EST_W'(cur_row.age[i]) > cur_row.est) ? '0 : rdrp_pkg::PRIO_NEAR)
                    + rdrp_pkg::PRIO_W'(cur_row.demand[i])
                    + rdrp_pkg::PRIO_W'(cur_row.reused[i]);
                tree[NPAD-1+i].age  = cur_row.age[i];
            end else begin
                tree[NPAD-1+i].prio = rdrp_pkg::PRIO_PAD;
                tree[NPAD-1+i].age  = '1;
            end
            tree[NPAD-1+i].way = WAY_W'(i);
        end
        for (int i = NPAD - 2; i >= 0; i--) begin
            if ({tree[2*i+2].prio, tree[2*i+2].age} < {tree[2*i+1].prio, tree[2*i+1].age}) begin
                tree[i] = tree[2*i+2];
            end else begin
                tree[i] = tree[2*i+1];
            end
        end
        best = tree[0];
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_command;
            r_set    <= SET_W'(i_set_index);
            r_way    <= WAY_W'(i_way_index);
            r_set_ok <= (32'(i_set_index) < SETS);
            r_way_ok <= (32'(i_way_index) < WAYS);
            r_pf     <= i_is_prefetch;
            r_hit    <= i_was_hit;
        end
    end

    // Control state and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
            r_victim   <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_CLEAR: begin
                    if (32'(r_clr_addr) == SETS - 1) begin
                        r_state <= ST_IDLE;
                    end
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_state <= ST_IDLE;
                    if (r_cmd == rdrp_pkg::CMD_VICTIM) begin
                        r_valid  <= 1'b1;
                        r_victim <= r_set_ok ? rdrp_pkg::VICTIM_W'(best.way) : '0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_valid;
    assign o_victim_way = r_victim;

`ifndef NO_ASSERTIONS
    // A result only follows the execute cycle of a victim request
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_EXEC && r_cmd == rdrp_pkg::CMD_VICTIM))
        else $error("result strobe without a victim request");

    // A transfer always moves to the execute cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_EXEC))
        else $error("transfer did not start execution");

    // The memory is never written while idle
    a_we_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state != ST_IDLE))
        else $error("row write while idle");

    // No results during the clearing pass
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_valid)
        else $error("result during clearing pass");
`endif

endmodule

// ===== tb/sv/tb_reuse_distance_replacement_policy.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reuse_distance_replacement_policy
// Self-checking bench for the replacement policy. A class keeps its own copy
// of the per-line ages and flags and the per-set counters, predicts each
// victim choice and checks the victim strobes in order. The stimulus is a
// short directed part, then random traffic aimed mostly at a few hot sets,
// then a long miss run that leaves one line much older than the rest, then a full epoch of hits.
// ----------------------------------------------------------------------------
module tb_reuse_distance_replacement_policy;

    localparam int N_SETS     = 64;
    localparam int N_WAYS     = 16;
    localparam int AGE_W      = 8;
    localparam int HIT_EPOCH  = 32;
    localparam int MISS_AGING = 8;
    localparam int N_RANDOM   = 1000;
    localparam int N_HOT      = 4;

    // ------------------------------------------------------------------------
    // Victim tracker: policy state copy plus queue of victims still due
    // ------------------------------------------------------------------------
    class victim_tracker;
        logic [AGE_W-1:0] age        [N_SETS*N_WAYS];
        logic             demand     [N_SETS*N_WAYS];
        logic             reused     [N_SETS*N_WAYS];
        logic [5:0]       hit_cnt    [N_SETS];
        logic [2:0]       miss_cnt   [N_SETS];
        logic [12:0]      age_sum    [N_SETS];
        logic [8:0]       reuse_est  [N_SETS];
        logic [rdrp_pkg::VICTIM_W-1:0] victims_due[$];
        int               mismatches;

        function new();
            foreach (age[i]) begin
                age[i]    = '0;
                demand[i] = 1'b0;
                reused[i] = 1'b0;
            end
            foreach (hit_cnt[s]) begin
                hit_cnt[s]   = '0;
                miss_cnt[s]  = '0;
                age_sum[s]   = '0;
                reuse_est[s] = '0;
            end
            mismatches = 0;
        endfunction

        // Priority: near bonus when age is within the reuse estimate, plus flags
        function int line_rank(int idx, int set);
            int p;
            p = (age[idx] > reuse_est[set]) ? 0 : 8;
            return p + int'(demand[idx]) + int'(reused[idx]);
        endfunction

        // Lowest priority, then smallest age, then lowest way
        function logic [rdrp_pkg::VICTIM_W-1:0] victim_of(int set);
            int best;
            int best_p;
            int p;
            best   = 0;
            best_p = line_rank(set * N_WAYS, set);
            for (int w = 1; w < N_WAYS; w++) begin
                p = line_rank(set * N_WAYS + w, set);
                if (p < best_p || (p == best_p &&
                        age[set * N_WAYS + w] < age[set * N_WAYS + best])) begin
                    best   = w;
                    best_p = p;
                end
            end
            return best[rdrp_pkg::VICTIM_W-1:0];
        endfunction

        // Accepted request transfer: update state or queue the victim
        function void note_request(logic cmd, logic [5:0] set, logic [3:0] way,
                                   logic pf, logic hit);
            int base;
            int idx;
            base = int'(set) * N_WAYS;
            idx  = base + int'(way);
            if (cmd == rdrp_pkg::CMD_VICTIM) begin
                victims_due.push_back(victim_of(int'(set)));
            end else if (hit) begin
                age_sum[set] = age_sum[set] + age[idx];
                age[idx]     = '0;
                demand[idx]  = !pf;
                reused[idx]  = 1'b1;
                hit_cnt[set] = hit_cnt[set] + 1'b1;
                if (hit_cnt[set] == HIT_EPOCH) begin
                    reuse_est[set] = 9'(age_sum[set] >> rdrp_pkg::EST_SHIFT);
                    age_sum[set]   = '0;
                    hit_cnt[set]   = '0;
                end
            end else begin
                // miss fill; whole set ages every 8th miss, saturating
                miss_cnt[set] = miss_cnt[set] + 1'b1;
                if (miss_cnt[set] == 3'd0) begin
                    for (int w = 0; w < N_WAYS; w++) begin
                        if (age[base + w] != {AGE_W{1'b1}})
                            age[base + w] = age[base + w] + 1'b1;
                    end
                end
                age[idx]    = '0;
                demand[idx] = !pf;
                reused[idx] = 1'b0;
            end
        endfunction

        function void check_victim(logic [rdrp_pkg::VICTIM_W-1:0] got);
            logic [rdrp_pkg::VICTIM_W-1:0] want;
            if (victims_due.size() == 0) begin
                $error("victim_way: no request pending, actual %0d", got);
                mismatches++;
            end else begin
                want = victims_due.pop_front();
                if (got !== want) begin
                    $error("victim_way mismatch: expected %0d, actual %0d", want, got);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return victims_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and signals
    // ------------------------------------------------------------------------
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic                          i_command = 1'b0;
    logic [rdrp_pkg::SET_IN_W-1:0] i_set_index = '0;
    logic [rdrp_pkg::WAY_IN_W-1:0] i_way_index = '0;
    logic                          i_is_prefetch = 1'b0;
    logic                          i_was_hit = 1'b0;
    logic                          o_valid;
    logic [rdrp_pkg::VICTIM_W-1:0] o_victim_way;

    victim_tracker trk = new();

    always #5 i_clk = ~i_clk;

    reuse_distance_replacement_policy #(
        .SETS     (N_SETS),
        .WAYS     (N_WAYS),
        .AGE_BITS (AGE_W)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_set_index   (i_set_index),
        .i_way_index   (i_way_index),
        .i_is_prefetch (i_is_prefetch),
        .i_was_hit     (i_was_hit),
        .o_valid       (o_valid),
        .o_victim_way  (o_victim_way)
    );

    // Victim strobes are taken at the edge that ends their cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1)
            trk.check_victim(o_victim_way);
    end

    // ------------------------------------------------------------------------
    // Request driver: random idle cycles, then hold until the transfer
    // ------------------------------------------------------------------------
    task automatic send_request(input logic cmd, input logic [5:0] set,
                                input logic [3:0] way, input logic pf,
                                input logic hit, input int idle_pct);
        bit taken;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start         <= 1'b1;
        i_command     <= cmd;
        i_set_index   <= set;
        i_way_index   <= way;
        i_is_prefetch <= pf;
        i_was_hit     <= hit;
        do begin
            @(posedge i_clk);
            taken = !busy;
            if (!taken)
                @(negedge i_clk);
        end while (!taken);
        trk.note_request(cmd, set, way, pf, hit);
    endtask

    task automatic ask_victim(input logic [5:0] set, input int idle_pct);
        send_request(rdrp_pkg::CMD_VICTIM, set, 4'($urandom), 1'($urandom),
                     1'($urandom), idle_pct);
    endtask

    // Timeout guard
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [5:0] hot_set [N_HOT];
        logic [5:0] set;
        logic [3:0] way;
        logic       cmd;
        logic       pf;
        logic       hit;
        int         idle_pct;
        int         sat_set;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: fresh sets, flag effects, one aging step, field extremes
        ask_victim(6'd0, 0);
        ask_victim(6'd63, 0);
        send_request(rdrp_pkg::CMD_RECORD, 6'd0, 4'd15, 1'b0, 1'b0, 0);
        send_request(rdrp_pkg::CMD_RECORD, 6'd0, 4'd0, 1'b1, 1'b0, 0);
        ask_victim(6'd0, 0);
        send_request(rdrp_pkg::CMD_RECORD, 6'd0, 4'd0, 1'b0, 1'b1, 0);
        ask_victim(6'd0, 0);
        for (int w = 0; w < MISS_AGING; w++)
            send_request(rdrp_pkg::CMD_RECORD, 6'd1, 4'(w), 1'(w), 1'b0, 0);
        ask_victim(6'd1, 0);
        send_request(rdrp_pkg::CMD_RECORD, 6'd63, 4'd15, 1'b1, 1'b1, 0);
        ask_victim(6'd63, 0);
        send_request(rdrp_pkg::CMD_RECORD, 6'd42, 4'd5, 1'b1, 1'b1, 0);
        ask_victim(6'd42, 0);

        // Random traffic, mostly on a few hot sets so epochs complete
        foreach (hot_set[h])
            hot_set[h] = 6'($urandom_range(N_SETS - 1));
        idle_pct = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0) begin
                case ((n / 100) % 4)
                    0: begin idle_pct = 0;  end
                    1: begin idle_pct = 72; end
                    2: begin idle_pct = 31; end
                    default: begin idle_pct = 0; end
                endcase
            end
            if ($urandom_range(99) < 80)
                set = hot_set[$urandom_range(N_HOT - 1)];
            else
                set = 6'($urandom);
            cmd = ($urandom_range(99) < 35) ? rdrp_pkg::CMD_VICTIM : rdrp_pkg::CMD_RECORD;
            hit = 1'($urandom);
            pf  = ($urandom_range(99) < 30);
            way = 4'($urandom);
            // miss fills usually go into the way the policy would evict
            if (cmd == rdrp_pkg::CMD_RECORD && !hit && $urandom_range(99) < 60)
                way = trk.victim_of(int'(set));
            send_request(cmd, set, way, pf, hit, idle_pct);
        end

        // Long miss run on one set, skipping way 0 so its age keeps climbing
        sat_set = $urandom_range(N_SETS - 1);
        for (int n = 0; n < 400; n++) begin
            send_request(rdrp_pkg::CMD_RECORD, 6'(sat_set), 4'(1 + n % (N_WAYS - 1)),
                         1'($urandom), 1'b0, (n < 200) ? 0 : 31);
            if (n % 50 == 49)
                ask_victim(6'(sat_set), 31);
        end
        ask_victim(6'(sat_set), 0);
        // One full epoch of hits, the first on the old line
        for (int n = 0; n < HIT_EPOCH; n++) begin
            send_request(rdrp_pkg::CMD_RECORD, 6'(sat_set),
                         (n == 0) ? 4'd0 : 4'($urandom), 1'($urandom), 1'b1, 31);
            if (n % 4 == 3)
                ask_victim(6'(sat_set), 0);
        end
        ask_victim(6'(sat_set), 0);

        @(negedge i_clk);
        start <= 1'b0;

        // Drain: wait for outstanding victims, then idle before the final check
        for (int c = 0; c < 200 && trk.pending() != 0; c++)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (trk.pending() != 0) begin
            $error("victim_way: %0d expected results never arrived", trk.pending());
            trk.mismatches++;
        end

        if (trk.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
